@@ design/msp_pkg.sv @@
`default_nettype none
package msp_pkg;

  localparam int MAX_SPHERES_DEF = 16;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W = 66;
  localparam int DOT_W = 66 - FRAC_BITS;
  localparam int DIV_W = 32 + FRAC_BITS;
  localparam int DIV_STEPS = DIV_W;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W = 6;
  localparam int ENTRY_W = 3 * 32 + 31;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QNORM = 2'd1,
    KIND_QUNIT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_SPHERE_COUNT = 3'd0,
    CFG_MARGIN       = 3'd1,
    CFG_SCALE_X      = 3'd2,
    CFG_SCALE_Y      = 3'd3,
    CFG_SCALE_Z      = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_STORE,
    OP_SQ_MUL,
    OP_SQ_WR,
    OP_UNIT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_T_MUL,
    OP_T_WR,
    OP_M_MUL,
    OP_M_WR,
    OP_FETCH,
    OP_R_MUL,
    OP_V_WR,
    OP_DOT_MUL,
    OP_DOT_WR,
    OP_CMP,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic ls_zero;
    logic n_zero;
    logic last;
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         sphere_index;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] support_x;
    logic signed [31:0] support_y;
    logic signed [31:0] support_z;
    logic               found;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (&x[PROD_W-1:31] || ~|x[PROD_W-1:31]) begin
      r = x[31:0];
    end else if (x[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage
`default_nettype wire

@@ design/multi_sphere_support_point.sv @@
// load item: busy while the entry is stored in the sphere table, no result
// unit-direction query: scaled and margin terms, then per sphere the support point, its dot product and the compare
// normalising query: first the squared length; a zero direction becomes the unit x direction, else
//   the bit-pair square root and three restoring divisions in Q16.16 normalise it
// one item at a time; start is taken only while busy is low; results cannot be stalled
// synchronous active-low reset clears control state and loads the register defaults
`default_nettype none
module multi_sphere_support_point #(
  parameter int MAX_SPHERES = msp_pkg::MAX_SPHERES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire msp_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output msp_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import msp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    accept;

  assign accept = start && !busy;

  msp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_item.kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  msp_dp #(
    .MAX_SPHERES (MAX_SPHERES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

@@ design/msp_ram.sv @@
`default_nettype none
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ design/msp_ctrl.sv @@
`default_nettype none
module msp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [1:0]       kind,
  input  wire msp_pkg::status_t status,
  output msp_pkg::cmd_t         cmd,
  output logic                  busy
);
  import msp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STORE,
    S_SQ_MUL,
    S_SQ_WR,
    S_LEN_CHK,
    S_UNIT,
    S_SQRT_INIT,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_END,
    S_PREP_MUL,
    S_PREP_WR,
    S_SPH_MUL,
    S_SPH_WR,
    S_CMP
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             busy_r, busy_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [2:0]       ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [1:0] ph_comp(input logic [2:0] ph);
    return (ph < 3'd3) ? ph[1:0] : 2'(ph - 3'd3);
  endfunction

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    ph_nxt      = ph_r;
    cnt_nxt     = cnt_r;
    cmd_nxt.op  = OP_NONE;
    cmd_nxt.k   = 2'd0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_LOAD: begin
              state_nxt  = S_STORE;
              cmd_nxt.op = OP_STORE;
            end
            KIND_QNORM: begin
              state_nxt  = S_SQ_MUL;
              k_nxt      = 2'd0;
              cmd_nxt.op = OP_SQ_MUL;
            end
            KIND_QUNIT: begin
              state_nxt  = S_PREP_MUL;
              ph_nxt     = 3'd0;
              cmd_nxt.op = OP_T_MUL;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_STORE: state_nxt = S_IDLE;
      S_SQ_MUL: begin
        state_nxt  = S_SQ_WR;
        cmd_nxt.op = OP_SQ_WR;
        cmd_nxt.k  = k_r;
      end
      S_SQ_WR: begin
        if (k_r != 2'd2) begin
          state_nxt  = S_SQ_MUL;
          k_nxt      = k_r + 2'd1;
          cmd_nxt.op = OP_SQ_MUL;
          cmd_nxt.k  = k_r + 2'd1;
        end else begin
          state_nxt = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        if (status.ls_zero) begin
          state_nxt  = S_UNIT;
          cmd_nxt.op = OP_UNIT;
        end else begin
          state_nxt  = S_SQRT_INIT;
          cmd_nxt.op = OP_SQRT_INIT;
        end
      end
      S_UNIT: begin
        state_nxt  = S_PREP_MUL;
        ph_nxt     = 3'd0;
        cmd_nxt.op = OP_T_MUL;
      end
      S_SQRT_INIT: begin
        state_nxt  = S_SQRT;
        cnt_nxt    = '0;
        cmd_nxt.op = OP_SQRT_STEP;
      end
      S_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt  = S_DIV_INIT;
          k_nxt      = 2'd0;
          cmd_nxt.op = OP_DIV_INIT;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          cmd_nxt.op = OP_SQRT_STEP;
        end
      end
      S_DIV_INIT: begin
        state_nxt  = S_DIV;
        cnt_nxt    = '0;
        cmd_nxt.op = OP_DIV_STEP;
        cmd_nxt.k  = k_r;
      end
      S_DIV: begin
        cmd_nxt.k = k_r;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt  = S_DIV_END;
          cmd_nxt.op = OP_DIV_END;
        end else begin
          cnt_nxt    = cnt_r + 1'b1;
          cmd_nxt.op = OP_DIV_STEP;
        end
      end
      S_DIV_END: begin
        if (k_r != 2'd2) begin
          state_nxt  = S_DIV_INIT;
          k_nxt      = k_r + 2'd1;
          cmd_nxt.op = OP_DIV_INIT;
          cmd_nxt.k  = k_r + 2'd1;
        end else begin
          state_nxt  = S_PREP_MUL;
          ph_nxt     = 3'd0;
          cmd_nxt.op = OP_T_MUL;
        end
      end
      S_PREP_MUL: begin
        state_nxt  = S_PREP_WR;
        cmd_nxt.op = (ph_r < 3'd3) ? OP_T_WR : OP_M_WR;
        cmd_nxt.k  = ph_comp(ph_r);
      end
      S_PREP_WR: begin
        if (ph_r != 3'd5) begin
          state_nxt  = S_PREP_MUL;
          ph_nxt     = ph_r + 3'd1;
          cmd_nxt.op = (ph_r + 3'd1 < 3'd3) ? OP_T_MUL : OP_M_MUL;
          cmd_nxt.k  = ph_comp(ph_r + 3'd1);
        end else if (status.n_zero) begin
          state_nxt  = S_IDLE;
          cmd_nxt.op = OP_OUT;
        end else begin
          state_nxt  = S_SPH_MUL;
          ph_nxt     = 3'd0;
          cmd_nxt.op = OP_FETCH;
        end
      end
      S_SPH_MUL: begin
        if (cmd_r.op == OP_FETCH) begin
          cmd_nxt.op = OP_R_MUL;
          cmd_nxt.k  = 2'd0;
        end else begin
          state_nxt  = S_SPH_WR;
          cmd_nxt.op = (ph_r < 3'd3) ? OP_V_WR : OP_DOT_WR;
          cmd_nxt.k  = ph_comp(ph_r);
        end
      end
      S_SPH_WR: begin
        if (ph_r != 3'd5) begin
          state_nxt  = S_SPH_MUL;
          ph_nxt     = ph_r + 3'd1;
          cmd_nxt.op = (ph_r + 3'd1 < 3'd3) ? OP_R_MUL : OP_DOT_MUL;
          cmd_nxt.k  = ph_comp(ph_r + 3'd1);
        end else begin
          state_nxt  = S_CMP;
          cmd_nxt.op = OP_CMP;
        end
      end
      S_CMP: begin
        if (status.last) begin
          state_nxt  = S_IDLE;
          cmd_nxt.op = OP_OUT;
        end else begin
          state_nxt  = S_SPH_MUL;
          ph_nxt     = 3'd0;
          cmd_nxt.op = OP_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE) || (cmd_nxt.op == OP_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cmd_r.op   <= OP_NONE;
      cmd_r.k    <= 2'd0;
      busy_r     <= 1'b0;
      k_r        <= 2'd0;
      ph_r       <= 3'd0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      busy_r  <= busy_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cmd  = cmd_r;
  assign busy = busy_r;

  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.op == OP_OUT |=> !busy_r)
    else $error("result op not followed by idle");

  a_cmp_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.op == OP_CMP |-> state_r == S_CMP)
    else $error("compare op outside compare state");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.k != 2'd3)
    else $error("component index out of range");

  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy_r)
    else $error("busy low while working");

endmodule
`default_nettype wire

@@ design/msp_dp.sv @@
`default_nettype none
module msp_dp #(
  parameter int MAX_SPHERES = 16,
  parameter int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire msp_pkg::in_item_t in_item,
  input  wire msp_pkg::cmd_t     cmd,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  output msp_pkg::status_t       status,
  output logic                   out_valid,
  output msp_pkg::out_item_t     out_item
);
  import msp_pkg::*;

  localparam logic [8:0] MAX9 = 9'(MAX_SPHERES);

  in_item_t                  in_r;
  logic [4:0]                count_r;
  logic [30:0]               margin_r;
  logic signed [31:0]        scale_r [3];
  logic signed [31:0]        d_r [3];
  logic signed [31:0]        t_r [3];
  logic signed [31:0]        mt_r [3];
  logic signed [31:0]        v_r [3];
  logic signed [31:0]        best_r [3];
  logic signed [DOT_W-1:0]   dot_r, best_dot_r;
  logic signed [PROD_W-1:0]  p_r;
  logic [63:0]               ls_r, sq_n_r, sq_res_r, sq_bit_r;
  logic [31:0]               rem_r;
  logic [DIV_W-1:0]          quo_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic signed [32:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0]  p_sh, vsum;
  logic signed [31:0]        rt;
  logic [63:0]               sq_sum;
  logic [32:0]               trial;
  logic                      trial_ok;
  logic [8:0]                n9, wr9;
  logic                      store_ok;
  logic [ENTRY_W-1:0]        rd_entry;
  logic signed [31:0]        c_x, c_y, c_z, c_k;
  logic [30:0]               rad;

  assign wr9      = {5'd0, in_r.sphere_index};
  assign store_ok = (cmd.op == OP_STORE) && (wr9 < MAX9);

  msp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SPHERES),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .we      (store_ok),
    .wr_addr (IDX_W'(wr9)),
    .wr_data ({in_r.centre_x, in_r.centre_y, in_r.centre_z, in_r.sphere_radius}),
    .rd_addr (idx_r),
    .rd_data (rd_entry)
  );

  assign {c_x, c_y, c_z, rad} = rd_entry;

  always_comb begin
    case (cmd.k)
      2'd0:    c_k = c_x;
      2'd1:    c_k = c_y;
      default: c_k = c_z;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = {1'b0, mag32(d_r[cmd.k])};
        mul_b = {1'b0, mag32(d_r[cmd.k])};
      end
      OP_T_MUL: begin
        mul_a = 33'(d_r[cmd.k]);
        mul_b = 33'(scale_r[cmd.k]);
      end
      OP_M_MUL: begin
        mul_a = 33'(d_r[cmd.k]);
        mul_b = {2'b00, margin_r};
      end
      OP_R_MUL: begin
        mul_a = 33'(t_r[cmd.k]);
        mul_b = {2'b00, rad};
      end
      OP_DOT_MUL: begin
        mul_a = 33'(d_r[cmd.k]);
        mul_b = 33'(v_r[cmd.k]);
      end
      default: ;
    endcase
  end

  assign p_sh     = p_r >>> FRAC_BITS;
  assign rt       = sat32(p_sh);
  assign vsum     = PROD_W'(c_k) + PROD_W'(rt) - PROD_W'(mt_r[cmd.k]);
  assign sq_sum   = sq_res_r + sq_bit_r;
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ok = trial >= {1'b0, sq_res_r[31:0]};

  assign n9 = ({4'd0, count_r} > MAX9) ? MAX9 : {4'd0, count_r};
  assign status.ls_zero = (ls_r == 64'd0);
  assign status.n_zero  = (n9 == 9'd0);
  assign status.last    = (9'(idx_r) + 9'd1 >= n9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 5'd0;
      margin_r    <= 31'd0;
      scale_r[0]  <= 32'sd1 <<< FRAC_BITS;
      scale_r[1]  <= 32'sd1 <<< FRAC_BITS;
      scale_r[2]  <= 32'sd1 <<< FRAC_BITS;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_OUT);
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SPHERE_COUNT: count_r    <= cfg_wdata[4:0];
          CFG_MARGIN:       margin_r   <= cfg_wdata[30:0];
          CFG_SCALE_X:      scale_r[0] <= cfg_wdata;
          CFG_SCALE_Y:      scale_r[1] <= cfg_wdata;
          CFG_SCALE_Z:      scale_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r      <= in_item;
      d_r[0]    <= in_item.dir_x;
      d_r[1]    <= in_item.dir_y;
      d_r[2]    <= in_item.dir_z;
      ls_r      <= 64'd0;
      idx_r     <= '0;
      best_r[0] <= 32'sd0;
      best_r[1] <= 32'sd0;
      best_r[2] <= 32'sd0;
    end
    p_r <= PROD_W'(mul_a * mul_b);
    case (cmd.op)
      OP_SQ_WR: ls_r <= ls_r + p_r[63:0];
      OP_UNIT: begin
        d_r[0] <= 32'sd1 <<< FRAC_BITS;
        d_r[1] <= 32'sd0;
        d_r[2] <= 32'sd0;
      end
      OP_SQRT_INIT: begin
        sq_n_r   <= ls_r;
        sq_res_r <= 64'd0;
        sq_bit_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sq_n_r >= sq_sum) begin
          sq_n_r   <= sq_n_r - sq_sum;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= 32'd0;
        quo_r <= {mag32(d_r[cmd.k]), {FRAC_BITS{1'b0}}};
      end
      OP_DIV_STEP: begin
        rem_r <= trial_ok ? 32'(trial - {1'b0, sq_res_r[31:0]}) : trial[31:0];
        quo_r <= {quo_r[DIV_W-2:0], trial_ok};
      end
      OP_DIV_END: d_r[cmd.k] <= d_r[cmd.k][31] ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);
      OP_T_WR:    t_r[cmd.k]  <= sat32(p_sh);
      OP_M_WR:    mt_r[cmd.k] <= sat32(p_sh);
      OP_FETCH:   dot_r <= '0;
      OP_V_WR:    v_r[cmd.k] <= sat32(vsum);
      OP_DOT_WR:  dot_r <= dot_r + DOT_W'(p_sh);
      OP_CMP: begin
        if (idx_r == '0 || dot_r > best_dot_r) begin
          best_dot_r <= dot_r;
          best_r[0]  <= v_r[0];
          best_r[1]  <= v_r[1];
          best_r[2]  <= v_r[2];
        end
        idx_r <= idx_r + 1'b1;
      end
      OP_OUT: begin
        out_item_r.support_x <= best_r[0];
        out_item_r.support_y <= best_r[1];
        out_item_r.support_z <= best_r[2];
        out_item_r.found     <= ~status.n_zero;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ bench/msp_checker.sv @@
module msp_checker
  import msp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  output int        fail_count,
  output int        pending
);

  logic [4:0] sphere_count_reg;
  longint     margin_reg;
  longint     scale_reg [3];
  longint     centre_tab [16][3];
  longint     radius_tab [16];
  out_item_t  support_q [$];

  assign pending = support_q.size();

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t support_of(in_item_t it);
    longint d [3];
    longint v [3];
    longint best [3];
    longint best_dot;
    longint dp;
    longint t;
    logic [63:0] mg [3];
    logic [63:0] len_sq;
    logic [63:0] len;
    logic [63:0] q;
    int n;
    bit hit;
    out_item_t r;
    d[0] = longint'(it.dir_x);
    d[1] = longint'(it.dir_y);
    d[2] = longint'(it.dir_z);
    best = '{0, 0, 0};
    best_dot = 0;
    hit = 0;
    if (it.kind == KIND_QNORM) begin
      for (int k = 0; k < 3; k++) mg[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
      len_sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      if (len_sq == 0) begin
        d = '{longint'(1) << FRAC_BITS, 0, 0};
      end else begin
        len = root64(len_sq);
        for (int k = 0; k < 3; k++) begin
          q = (mg[k] << FRAC_BITS) / len;
          d[k] = d[k] < 0 ? -longint'(q) : longint'(q);
        end
      end
    end
    n = sphere_count_reg > 16 ? 16 : sphere_count_reg;
    for (int i = 0; i < n; i++) begin
      dp = 0;
      for (int k = 0; k < 3; k++) begin
        t = clamp32(fxmul(d[k], scale_reg[k]));
        v[k] = clamp32(centre_tab[i][k] + clamp32(fxmul(t, radius_tab[i]))
                       - clamp32(fxmul(d[k], margin_reg)));
        dp += fxmul(d[k], v[k]);
      end
      if (!hit || dp > best_dot) begin
        hit = 1;
        best_dot = dp;
        best = v;
      end
    end
    r.support_x = best[0][31:0];
    r.support_y = best[1][31:0];
    r.support_z = best[2][31:0];
    r.found = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      sphere_count_reg <= 0;
      margin_reg <= 0;
      scale_reg <= '{65536, 65536, 65536};
      support_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SPHERE_COUNT: sphere_count_reg <= cfg_wdata[4:0];
          CFG_MARGIN:       margin_reg <= longint'(cfg_wdata[30:0]);
          CFG_SCALE_X:      scale_reg[0] <= longint'(signed'(cfg_wdata));
          CFG_SCALE_Y:      scale_reg[1] <= longint'(signed'(cfg_wdata));
          CFG_SCALE_Z:      scale_reg[2] <= longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.kind == KIND_LOAD) begin
          centre_tab[in_item.sphere_index][0] <= longint'(in_item.centre_x);
          centre_tab[in_item.sphere_index][1] <= longint'(in_item.centre_y);
          centre_tab[in_item.sphere_index][2] <= longint'(in_item.centre_z);
          radius_tab[in_item.sphere_index] <= longint'(in_item.sphere_radius);
        end else if (in_item.kind != KIND_NONE) begin
          support_q.push_back(support_of(in_item));
        end
      end
      if (out_valid) begin
        if (support_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_item);
        end else begin
          if (support_q[0].support_x !== out_item.support_x ||
              support_q[0].support_y !== out_item.support_y ||
              support_q[0].support_z !== out_item.support_z ||
              support_q[0].found !== out_item.found) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected x=%h y=%h z=%h found=%b, got x=%h y=%h z=%h found=%b",
                       support_q[0].support_x, support_q[0].support_y,
                       support_q[0].support_z, support_q[0].found,
                       out_item.support_x, out_item.support_y,
                       out_item.support_z, out_item.found);
          end
          void'(support_q.pop_front());
        end
      end
    end
  end

endmodule

@@ bench/multi_sphere_support_point_tb.sv @@
module multi_sphere_support_point_tb;
  import msp_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         idle_cycles;
  bit         no_gaps;

  multi_sphere_support_point i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  msp_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 600)) - 300);
      2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    if (no_gaps) return 0;
    case ($urandom_range(0, 19))
      0: return $urandom_range(10, 60);
      1, 2, 3, 4, 5: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int sel;
    it.sphere_index = $urandom;
    it.centre_x = pick32();
    it.centre_y = pick32();
    it.centre_z = pick32();
    it.sphere_radius = pick32();
    it.dir_x = pick32();
    it.dir_y = pick32();
    it.dir_z = pick32();
    if ($urandom_range(0, 15) == 0) begin
      it.dir_x = 0;
      it.dir_y = 0;
      it.dir_z = 0;
    end
    sel = $urandom_range(0, 19);
    if (sel < 5) it.kind = KIND_LOAD;
    else if (sel < 12) it.kind = KIND_QNORM;
    else if (sel < 19) it.kind = KIND_QUNIT;
    else it.kind = KIND_NONE;
    return it;
  endfunction

  task automatic send(in_item_t it);
    int gap;
    gap = pick_gap();
    in_item <= it;
    start <= 1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_all(logic [31:0] cnt, logic [31:0] mrg, logic [31:0] sx,
                         logic [31:0] sy, logic [31:0] sz);
    drain();
    write_cfg(CFG_SPHERE_COUNT, cnt);
    write_cfg(CFG_MARGIN, mrg);
    write_cfg(CFG_SCALE_X, sx);
    write_cfg(CFG_SCALE_Y, sy);
    write_cfg(CFG_SCALE_Z, sz);
  endtask

  initial begin
    in_item_t it;
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // no spheres configured
    it = rand_item();
    it.kind = KIND_QUNIT;
    send(it);
    it.kind = KIND_QNORM;
    send(it);

    // fill the table, extremes of centre and radius
    for (int i = 0; i < 16; i++) begin
      it = rand_item();
      it.kind = KIND_LOAD;
      it.sphere_index = i;
      if (i == 0) begin
        it.centre_x = 32'h7fff_ffff; it.centre_y = 32'h8000_0000;
        it.centre_z = 0; it.sphere_radius = 31'h7fff_ffff;
      end else if (i == 1) begin
        it.centre_x = 32'h8000_0000; it.centre_y = 32'h7fff_ffff;
        it.centre_z = 32'hffff_ffff; it.sphere_radius = 0;
      end
      send(it);
    end

    set_all(16, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    it = rand_item();
    it.kind = KIND_QNORM;
    it.dir_x = 0; it.dir_y = 0; it.dir_z = 0;
    send(it);
    it.kind = KIND_QUNIT;
    send(it);
    it.kind = KIND_QNORM;
    it.dir_x = 32'h7fff_ffff; it.dir_y = 32'h7fff_ffff; it.dir_z = 32'h7fff_ffff;
    send(it);
    it.dir_x = 32'h8000_0000; it.dir_y = 32'h8000_0000; it.dir_z = 32'h8000_0000;
    send(it);
    it.kind = KIND_QUNIT;
    send(it);
    it.dir_x = 32'h7fff_ffff; it.dir_y = 32'h8000_0000; it.dir_z = 32'h0001_0000;
    send(it);
    it.kind = KIND_NONE;
    send(it);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_all(31, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
        1: set_all($urandom_range(1, 16), $urandom_range(0, 1 << 18),
                   pick32(), pick32(), pick32());
        2: set_all(1, $urandom, $urandom, $urandom, $urandom);
        3: set_all(0, $urandom, pick32(), pick32(), pick32());
        4: set_all(16, $urandom_range(0, 1 << 16), 32'h0001_0000,
                   32'hffff_0000, 32'h0000_8000);
        default: set_all($urandom_range(0, 31), pick32(), pick32(), pick32(), pick32());
      endcase
      for (int n = 0; n < 320; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send(rand_item());
      end
    end

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/msp_pkg.sv
design/msp_ram.sv
design/msp_ctrl.sv
design/msp_dp.sv
design/multi_sphere_support_point.sv
bench/msp_checker.sv
bench/multi_sphere_support_point_tb.sv
